>>> rtl/bir_pkg.sv
// Shared types, constants and codes for the bilinear image resize block.
`timescale 1ns / 1ps

package bir_pkg;

  // Parameter defaults
  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;
  localparam int DEF_PIXEL_BITS = 16;

  // Fixed-point layout: coordinates and weights in units of 2^-17
  localparam int FRAC_BITS = 17;
  localparam int IDX_W     = 17;          // integer part of a mapped coordinate
  localparam int WGT_W     = FRAC_BITS + 1;

  // Result buffer depth, also the number of requests allowed in flight
  localparam int FIFO_DEPTH = 4;

  // Last of the four plane reads of one request
  localparam logic [1:0] LAST_BEAT = 2'b11;

  // Input operation codes
  localparam logic OP_STORE   = 1'b0;
  localparam logic OP_REQUEST = 1'b1;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_STEP_H = 2'd2,
    CFG_STEP_V = 2'd3
  } cfg_reg_e;

  // Configuration register contents
  typedef struct packed {
    logic [8:0]  width;
    logic [8:0]  height;
    logic [23:0] step_h;
    logic [23:0] step_v;
  } cfg_t;

  // Control of one item leaving the coordinate unit
  typedef struct packed {
    logic op;
    logic keep;   // store lands inside the plane
  } item_ctrl_t;

  // Blend fractions of one request
  typedef struct packed {
    logic [FRAC_BITS-1:0] fx;
    logic [FRAC_BITS-1:0] fy;
  } frac_t;

  // Tag that travels with one plane read
  typedef struct packed {
    logic                 valid;
    logic [1:0]           pos;    // bit 0: right neighbor, bit 1: lower row
    logic [FRAC_BITS-1:0] fx;
    logic [FRAC_BITS-1:0] fy;
  } tag_t;

endpackage

>>> rtl/bir_plane.sv
// Single-port source plane memory with registered read data.
`timescale 1ns / 1ps

module bir_plane #(
  parameter int ADDR_W = 16,
  parameter int DATA_W = 16
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] addr_i,
  input  logic [DATA_W-1:0] wdata_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [2**ADDR_W];
  logic [DATA_W-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
  end

  // Read port, data registered
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/bir_coord.sv
// Coordinate unit: maps requests to clamped source neighbors and fractions, passes stores on.
`timescale 1ns / 1ps

module bir_coord import bir_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int PIXEL_BITS = DEF_PIXEL_BITS,
  parameter int COL_W      = $clog2(MAX_WIDTH),
  parameter int ROW_W      = $clog2(MAX_HEIGHT)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cfg_t                  cfg_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  op_i,
  input  logic [7:0]            column_i,
  input  logic [7:0]            row_i,
  input  logic [PIXEL_BITS-1:0] pixel_in_i,
  output logic                  item_valid_o,
  output item_ctrl_t            item_ctrl_o,
  output logic [COL_W-1:0]      left_o,
  output logic [COL_W-1:0]      right_o,
  output logic [ROW_W-1:0]      upper_o,
  output logic [ROW_W-1:0]      lower_o,
  output frac_t                 frac_o,
  output logic [PIXEL_BITS-1:0] pixel_o,
  input  logic                  item_pop_i
);

  // Size register as used: zero acts as one, above the plane acts as the plane
  function automatic logic [IDX_W-1:0] eff_size(logic [8:0] v, logic [IDX_W-1:0] lim);
    logic [IDX_W-1:0] ext;
    ext = {{(IDX_W-9){1'b0}}, v};
    if (ext == '0) begin
      eff_size = {{(IDX_W-1){1'b0}}, 1'b1};
    end else if (ext > lim) begin
      eff_size = lim;
    end else begin
      eff_size = ext;
    end
  endfunction

  // Floored integer part p of a coordinate, clamped as the low neighbor p-1
  function automatic logic [IDX_W-1:0] clamp_low(logic [IDX_W-1:0] p, logic [IDX_W-1:0] s);
    if (p == '0) begin
      clamp_low = '0;
    end else if (p > s) begin
      clamp_low = s - IDX_W'(1);
    end else begin
      clamp_low = p - IDX_W'(1);
    end
  endfunction

  // High neighbor p clamped to the last pixel
  function automatic logic [IDX_W-1:0] clamp_high(logic [IDX_W-1:0] p, logic [IDX_W-1:0] s);
    if (p >= s) begin
      clamp_high = s - IDX_W'(1);
    end else begin
      clamp_high = p;
    end
  endfunction

  localparam int PROD_W = 33;   // (2k+1) * step
  localparam int TOT_W  = 34;   // plus half a pixel offset

  // Stage 1: products
  logic                  s1_valid_q, s1_valid_d;
  logic                  s1_op_q;
  logic [7:0]            s1_col_q, s1_row_q;
  logic [PIXEL_BITS-1:0] s1_pix_q;
  logic [PROD_W-1:0]     s1_mx_q, s1_mx_d, s1_my_q, s1_my_d;

  // Stage 2: neighbors and fractions
  logic                  s2_valid_q, s2_valid_d;
  item_ctrl_t            s2_ctrl_q, s2_ctrl_d;
  logic [COL_W-1:0]      s2_left_q, s2_left_d, s2_right_q, s2_right_d;
  logic [ROW_W-1:0]      s2_upper_q, s2_upper_d, s2_lower_q, s2_lower_d;
  frac_t                 s2_frac_q, s2_frac_d;
  logic [PIXEL_BITS-1:0] s2_pix_q;

  logic s2_ready, s1_load, s2_load;

  // Handshake along the two stages
  assign s2_ready   = !s2_valid_q || item_pop_i;
  assign in_ready_o = !s1_valid_q || s2_ready;
  assign s1_load    = in_valid_i && in_ready_o;
  assign s2_load    = s1_valid_q && s2_ready;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (s1_load) begin
      s1_valid_d = 1'b1;
    end else if (s2_load) begin
      s1_valid_d = 1'b0;
    end
    s2_valid_d = s2_valid_q;
    if (s2_load) begin
      s2_valid_d = 1'b1;
    end else if (item_pop_i) begin
      s2_valid_d = 1'b0;
    end
  end

  // Source coordinate times 2^17 plus 2^17: (2k+1)*step + 2^16
  assign s1_mx_d = PROD_W'({column_i, 1'b1}) * PROD_W'(cfg_i.step_h);
  assign s1_my_d = PROD_W'({row_i, 1'b1}) * PROD_W'(cfg_i.step_v);

  // Floor, clamp and split into index and fraction
  always_comb begin
    logic [TOT_W-1:0] tx, ty;
    logic [IDX_W-1:0] px, py, w_eff, h_eff, lx, rx, uy, dy, cx, ry;
    tx    = {1'b0, s1_mx_q} + (TOT_W'(1) << (FRAC_BITS - 1));
    ty    = {1'b0, s1_my_q} + (TOT_W'(1) << (FRAC_BITS - 1));
    px    = tx[TOT_W-1:FRAC_BITS];
    py    = ty[TOT_W-1:FRAC_BITS];
    w_eff = eff_size(cfg_i.width, IDX_W'(MAX_WIDTH));
    h_eff = eff_size(cfg_i.height, IDX_W'(MAX_HEIGHT));
    lx    = clamp_low(px, w_eff);
    rx    = clamp_high(px, w_eff);
    uy    = clamp_low(py, h_eff);
    dy    = clamp_high(py, h_eff);
    cx    = {{(IDX_W-8){1'b0}}, s1_col_q};
    ry    = {{(IDX_W-8){1'b0}}, s1_row_q};

    s2_ctrl_d.op      = s1_op_q;
    s2_ctrl_d.keep    = (cx < IDX_W'(MAX_WIDTH)) && (ry < IDX_W'(MAX_HEIGHT));
    s2_frac_d.fx      = tx[FRAC_BITS-1:0];
    s2_frac_d.fy      = ty[FRAC_BITS-1:0];
    s2_right_d        = rx[COL_W-1:0];
    s2_lower_d        = dy[ROW_W-1:0];
    // Stores reuse the upper-left slot for their own address
    if (s1_op_q == OP_STORE) begin
      s2_left_d  = cx[COL_W-1:0];
      s2_upper_d = ry[ROW_W-1:0];
    end else begin
      s2_left_d  = lx[COL_W-1:0];
      s2_upper_d = uy[ROW_W-1:0];
    end
  end

  // Valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s2_valid_d;
    end
  end

  // Stage payload
  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_op_q  <= op_i;
      s1_col_q <= column_i;
      s1_row_q <= row_i;
      s1_pix_q <= pixel_in_i;
      s1_mx_q  <= s1_mx_d;
      s1_my_q  <= s1_my_d;
    end
    if (s2_load) begin
      s2_ctrl_q  <= s2_ctrl_d;
      s2_left_q  <= s2_left_d;
      s2_right_q <= s2_right_d;
      s2_upper_q <= s2_upper_d;
      s2_lower_q <= s2_lower_d;
      s2_frac_q  <= s2_frac_d;
      s2_pix_q   <= s1_pix_q;
    end
  end

  assign item_valid_o = s2_valid_q;
  assign item_ctrl_o  = s2_ctrl_q;
  assign left_o       = s2_left_q;
  assign right_o      = s2_right_q;
  assign upper_o      = s2_upper_q;
  assign lower_o      = s2_lower_q;
  assign frac_o       = s2_frac_q;
  assign pixel_o      = s2_pix_q;

endmodule

>>> rtl/bir_blend.sv
// Blend pipeline: horizontal then vertical weighting, rounding, result buffer.
`timescale 1ns / 1ps

module bir_blend import bir_pkg::*; #(
  parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  tag_t                  tag_i,
  input  logic [PIXEL_BITS-1:0] rdata_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [PIXEL_BITS-1:0] pixel_o
);

  localparam int HW    = PIXEL_BITS + FRAC_BITS;       // one blended row
  localparam int VW    = PIXEL_BITS + 2 * FRAC_BITS;   // final sum
  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
  localparam logic [WGT_W-1:0] ONE = WGT_W'(1) << FRAC_BITS;

  // Horizontal product stage
  logic                 h_valid_q;
  logic [1:0]           h_pos_q;
  logic [FRAC_BITS-1:0] h_fy_q;
  logic [HW-1:0]        h_prod_q, h_prod_d;
  logic [WGT_W-1:0]     wx;

  // Row sum stage
  logic                 r_valid_q, r_valid_d;
  logic                 r_sel_q;
  logic [FRAC_BITS-1:0] r_fy_q;
  logic [HW-1:0]        r_acc_q, r_sum_q;

  // Vertical product stage
  logic                 v_valid_q;
  logic                 v_sel_q;
  logic [VW-1:0]        v_prod_q, v_prod_d;
  logic [WGT_W-1:0]     wy;

  // Final sum
  logic [VW-1:0]        f_acc_q;
  logic [VW-1:0]        f_round;
  logic                 push;

  // Result buffer
  logic [PIXEL_BITS-1:0] fifo_q [FIFO_DEPTH];
  logic [PTR_W-1:0]      wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic                  pop;

  // Pixel times its horizontal weight; the value stays below 2^HW
  always_comb begin
    logic [PIXEL_BITS+WGT_W-1:0] full;
    wx       = tag_i.pos[0] ? {1'b0, tag_i.fx} : ONE - {1'b0, tag_i.fx};
    full     = (PIXEL_BITS + WGT_W)'(rdata_i) * (PIXEL_BITS + WGT_W)'(wx);
    h_prod_d = full[HW-1:0];
  end

  // Row value times its vertical weight
  always_comb begin
    wy       = r_sel_q ? {1'b0, r_fy_q} : ONE - {1'b0, r_fy_q};
    v_prod_d = VW'(r_sum_q) * VW'(wy);
  end

  // Round half up; a full-scale blend rounds to full scale, so no overflow
  assign f_round   = f_acc_q + v_prod_q + (VW'(1) << (2 * FRAC_BITS - 1));
  assign push      = v_valid_q && v_sel_q;
  assign r_valid_d = h_valid_q && h_pos_q[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_valid_q <= 1'b0;
      r_valid_q <= 1'b0;
      v_valid_q <= 1'b0;
    end else begin
      h_valid_q <= tag_i.valid;
      r_valid_q <= r_valid_d;
      v_valid_q <= r_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    h_pos_q  <= tag_i.pos;
    h_fy_q   <= tag_i.fy;
    h_prod_q <= h_prod_d;
    // Left neighbor opens a row, right neighbor closes it
    if (h_valid_q && !h_pos_q[0]) begin
      r_acc_q <= h_prod_q;
    end
    if (r_valid_d) begin
      r_sum_q <= r_acc_q + h_prod_q;
      r_sel_q <= h_pos_q[1];
      r_fy_q  <= h_fy_q;
    end
    v_sel_q  <= r_sel_q;
    v_prod_q <= v_prod_d;
    // Upper row opens the sum, lower row closes it
    if (v_valid_q && !v_sel_q) begin
      f_acc_q <= v_prod_q;
    end
    if (push) begin
      fifo_q[wr_ptr_q] <= f_round[VW-1:2*FRAC_BITS];
    end
  end

  // Buffer pointers and fill level
  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (cnt_q != '0);
  assign pixel_o     = fifo_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
      cnt_q <= cnt_d;
    end
  end

endmodule

>>> rtl/bilinear_image_resize.sv
// Top level of the bilinear image resize block: configuration, read sequencer, plane.
`timescale 1ns / 1ps

// Holds one source plane in a single-port memory and answers resize requests.
// A store item takes one access of the plane port; a request takes four, one
// read for each of the four neighbors. Stores go one per cycle while no request
// holds the port, mixed freely with requests. Up to four requests may be in
// flight, limited by the result buffer. The plane is not cleared after reset:
// a request must only touch entries that were stored. Configuration writes
// take effect at once and are meant for an idle block.

module bilinear_image_resize import bir_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  op_i,
  input  logic [7:0]            column_i,
  input  logic [7:0]            row_i,
  input  logic [PIXEL_BITS-1:0] pixel_in_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [PIXEL_BITS-1:0] pixel_out_o,
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_index_i,
  input  logic [23:0]           cfg_data_i
);

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int ADDR_W = ROW_W + COL_W;
  localparam int CRD_W  = $clog2(FIFO_DEPTH + 1);

  // Configuration registers
  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_WIDTH:  cfg_d.width  = cfg_data_i[8:0];
        CFG_HEIGHT: cfg_d.height = cfg_data_i[8:0];
        CFG_STEP_H: cfg_d.step_h = cfg_data_i;
        CFG_STEP_V: cfg_d.step_v = cfg_data_i;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.width  <= 9'd256;
      cfg_q.height <= 9'd256;
      cfg_q.step_h <= 24'd65536;
      cfg_q.step_v <= 24'd65536;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Coordinate unit
  logic                  item_valid, item_pop;
  item_ctrl_t            item_ctrl;
  logic [COL_W-1:0]      item_left, item_right;
  logic [ROW_W-1:0]      item_upper, item_lower;
  frac_t                 item_frac;
  logic [PIXEL_BITS-1:0] item_pixel;

  bir_coord #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .PIXEL_BITS (PIXEL_BITS),
    .COL_W      (COL_W),
    .ROW_W      (ROW_W)
  ) u_coord (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .op_i         (op_i),
    .column_i     (column_i),
    .row_i        (row_i),
    .pixel_in_i   (pixel_in_i),
    .item_valid_o (item_valid),
    .item_ctrl_o  (item_ctrl),
    .left_o       (item_left),
    .right_o      (item_right),
    .upper_o      (item_upper),
    .lower_o      (item_lower),
    .frac_o       (item_frac),
    .pixel_o      (item_pixel),
    .item_pop_i   (item_pop)
  );

  // Read sequencer: four neighbor reads per request, one port access per store
  logic [1:0]        beat_q;
  logic [CRD_W-1:0]  credit_q, credit_d;
  logic              is_req, is_store, start, issue, out_pop;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_addr;
  tag_t              tag_q, tag_d;

  assign is_req   = item_valid && (item_ctrl.op == OP_REQUEST);
  assign is_store = item_valid && (item_ctrl.op == OP_STORE);
  assign start    = is_req && (beat_q == '0) && (credit_q < CRD_W'(FIFO_DEPTH));
  assign issue    = is_req && ((beat_q != '0) || start);
  assign item_pop = is_store || (issue && (beat_q == LAST_BEAT));
  assign mem_we   = is_store && item_ctrl.keep;
  assign out_pop  = out_valid_o && out_ready_i;

  // Port address: the store's own entry, or the neighbor of this beat
  always_comb begin
    if (is_store) begin
      mem_addr = {item_upper, item_left};
    end else begin
      mem_addr = {beat_q[1] ? item_lower : item_upper, beat_q[0] ? item_right : item_left};
    end
  end

  always_comb begin
    tag_d.valid = issue;
    tag_d.pos   = beat_q;
    tag_d.fx    = item_frac.fx;
    tag_d.fy    = item_frac.fy;
  end

  // Requests in flight, up to the result buffer depth
  always_comb begin
    credit_d = credit_q;
    if (start && !out_pop) begin
      credit_d = credit_q + CRD_W'(1);
    end else if (out_pop && !start) begin
      credit_d = credit_q - CRD_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beat_q   <= '0;
      credit_q <= '0;
      tag_q    <= '0;
    end else begin
      if (issue) begin
        beat_q <= beat_q + 2'd1;
      end
      credit_q <= credit_d;
      tag_q    <= tag_d;
    end
  end

  // Source plane
  logic [PIXEL_BITS-1:0] rdata;

  bir_plane #(
    .ADDR_W (ADDR_W),
    .DATA_W (PIXEL_BITS)
  ) u_plane (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .re_i    (issue),
    .addr_i  (mem_addr),
    .wdata_i (item_pixel),
    .rdata_o (rdata)
  );

  // Blend and result buffer
  bir_blend #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_blend (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tag_i       (tag_q),
    .rdata_i     (rdata),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .pixel_o     (pixel_out_o)
  );

`ifndef SYNTHESIS
  // Never more requests in flight than the buffer can hold
  a_credit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    credit_q <= CRD_W'(FIFO_DEPTH))
    else $error("request credit above buffer depth");

  // A request in mid-sequence keeps its item at the head
  a_beat_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (beat_q != '0) |-> is_req)
    else $error("read sequence lost its request");

  // A result on the output always belongs to a counted request
  a_out_credit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (credit_q != '0))
    else $error("result without an outstanding request");

  // Each request runs four consecutive reads
  a_beat_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (issue && (beat_q != LAST_BEAT)) |=> issue)
    else $error("read sequence broken before the last neighbor");
`endif

endmodule

>>> tb/bilinear_image_resize_tb.sv
// Self-checking testbench for the bilinear image resize block: random stores and requests.
`timescale 1ns / 1ps

module bilinear_image_resize_tb;
  import bir_pkg::*;

  localparam int TOTAL_ITEMS   = 1750;
  localparam int CALM_ITEMS    = 200;
  localparam int PHASE_DRAWS   = 120;
  localparam int SETTLE_CYCLES = 16;
  localparam int QUIET_LIMIT   = 4000;

  // Keeps a shadow of the plane and the registers and the pixels still owed by the block
  class resize_scoreboard;
    localparam int PLANE_W = DEF_MAX_WIDTH;
    localparam int PLANE_H = DEF_MAX_HEIGHT;
    localparam longint ONE = longint'(1) << FRAC_BITS;

    bit [15:0]   plane [PLANE_W*PLANE_H];
    bit          stored [PLANE_W*PLANE_H];
    bit [8:0]    width_reg;
    bit [8:0]    height_reg;
    bit [23:0]   step_h;
    bit [23:0]   step_v;
    bit [15:0]   pending_pixels [$];
    int unsigned mismatches;
    int unsigned stores;
    int unsigned requests;
    int unsigned results;
    int unsigned settings;

    function new();
      width_reg  = 9'd256;
      height_reg = 9'd256;
      step_h     = 24'd65536;
      step_v     = 24'd65536;
    endfunction

    function void set_reg(cfg_reg_e idx, bit [23:0] data);
      case (idx)
        CFG_WIDTH:  width_reg  = data[8:0];
        CFG_HEIGHT: height_reg = data[8:0];
        CFG_STEP_H: step_h     = data;
        CFG_STEP_V: step_v     = data;
        default: ;
      endcase
    endfunction

    // Source coordinate in 2^-17 units, shifted up by one pixel so it never goes negative
    function longint unsigned shifted_coord(bit [7:0] k, bit [23:0] s);
      return longint'(2) * longint'(k) * longint'(s) + longint'(s) - 65536 + ONE;
    endfunction

    // Out-of-range size registers act as the nearest legal size
    function int unsigned clamp_index(longint v, bit [8:0] size_reg, int unsigned max);
      int unsigned size;
      size = (size_reg == 0) ? 1 : (size_reg > max) ? max : size_reg;
      if (v < 0) return 0;
      if (v > longint'(size) - 1) return size - 1;
      return int'(v);
    endfunction

    // Plane address of one neighbor: bit 0 picks the right column, bit 1 the lower row
    function int unsigned corner_addr(bit [7:0] col, bit [7:0] row, bit [1:0] corner);
      longint xi;
      longint yi;
      xi = longint'(shifted_coord(col, step_h) >> FRAC_BITS) - 1 + longint'(corner[0]);
      yi = longint'(shifted_coord(row, step_v) >> FRAC_BITS) - 1 + longint'(corner[1]);
      return clamp_index(yi, height_reg, PLANE_H) * PLANE_W
             + clamp_index(xi, width_reg, PLANE_W);
    endfunction

    // Exact bilinear blend, rounded half up, saturated
    function bit [15:0] blend_pixel(bit [7:0] col, bit [7:0] row);
      longint unsigned fx;
      longint unsigned fy;
      longint unsigned top;
      longint unsigned bot;
      longint unsigned sum;
      fx  = shifted_coord(col, step_h) & (ONE - 1);
      fy  = shifted_coord(row, step_v) & (ONE - 1);
      top = plane[corner_addr(col, row, 2'd0)] * (ONE - fx)
            + plane[corner_addr(col, row, 2'd1)] * fx;
      bot = plane[corner_addr(col, row, 2'd2)] * (ONE - fx)
            + plane[corner_addr(col, row, 2'd3)] * fx;
      sum = top * (ONE - fy) + bot * fy;
      sum = (sum + (longint'(1) << (2 * FRAC_BITS - 1))) >> (2 * FRAC_BITS);
      return (sum > 65535) ? 16'hFFFF : sum[15:0];
    endfunction

    function void note_item(logic op, bit [7:0] col, bit [7:0] row, bit [15:0] pix);
      if (op == OP_STORE) begin
        plane[{row, col}]  = pix;
        stored[{row, col}] = 1'b1;
        stores++;
      end else begin
        pending_pixels.push_back(blend_pixel(col, row));
        requests++;
      end
    endfunction

    task report_mismatch(string what);
      $display("%0t mismatch: %s", $realtime, what);
      mismatches++;
    endtask

    task check_pixel(bit [15:0] got);
      bit [15:0] want;
      if (pending_pixels.size() == 0) begin
        report_mismatch($sformatf("pixel_out %h with no request pending", got));
      end else begin
        want = pending_pixels.pop_front();
        results++;
        if (got !== want)
          report_mismatch($sformatf("pixel_out %h, expected %h", got, want));
      end
    endtask
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic        op_i;
  logic [7:0]  column_i;
  logic [7:0]  row_i;
  logic [15:0] pixel_in_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [15:0] pixel_out_o;
  logic        cfg_we_i;
  logic [1:0]  cfg_index_i;
  logic [23:0] cfg_data_i;

  resize_scoreboard sb;
  int          quiet_cycles = 0;
  bit          calm = 1'b0;
  int unsigned gap_pct = 10;
  int unsigned stall_pct = 10;

  bilinear_image_resize u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .op_i        (op_i),
    .column_i    (column_i),
    .row_i       (row_i),
    .pixel_in_i  (pixel_in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .pixel_out_o (pixel_out_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Monitor: both channels sampled at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note_item(op_i, column_i, row_i, pixel_in_i);
      if (out_valid_o && out_ready_i) sb.check_pixel(pixel_out_o);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Watchdog on handshake activity
  initial begin
    wait (rst_ni === 1'b1);
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk_i);
    $display("no handshake for %0d cycles", QUIET_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  // Result side: random stall bursts on out_ready
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!calm && $urandom_range(0, 99) < stall_pct) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(0, 14)) @(negedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // One item on the input channel, with an optional gap in front
  task automatic send_item(logic op, bit [7:0] col, bit [7:0] row, bit [15:0] pix);
    @(negedge clk_i);
    if (!calm && $urandom_range(0, 99) < gap_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i       <= op;
    column_i   <= col;
    row_i      <= row;
    pixel_in_i <= pix;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // Resize request; neighbors never stored get a random pixel first
  task automatic request_pixel(bit [7:0] col, bit [7:0] row);
    int unsigned addr [4];
    bit dup;
    int n;
    int m;
    for (n = 0; n < 4; n++) begin
      addr[n] = sb.corner_addr(col, row, n[1:0]);
      dup = 1'b0;
      for (m = 0; m < n; m++) if (addr[m] == addr[n]) dup = 1'b1;
      if (!dup && !sb.stored[addr[n]])
        send_item(OP_STORE, addr[n][7:0], addr[n][15:8], 16'($urandom));
    end
    send_item(OP_REQUEST, col, row, 16'($urandom));
  endtask

  // Hold the input side until every pending pixel is out and the plane port is quiet
  task automatic drain_requests();
    @(negedge clk_i) in_valid_i <= 1'b0;
    while (sb.pending_pixels.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, bit [23:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    sb.set_reg(idx, data);
  endtask

  task automatic configure(bit [23:0] w, bit [23:0] h, bit [23:0] sh, bit [23:0] sv);
    write_reg(CFG_WIDTH, w);
    write_reg(CFG_HEIGHT, h);
    write_reg(CFG_STEP_H, sh);
    write_reg(CFG_STEP_V, sv);
    @(negedge clk_i) cfg_we_i <= 1'b0;
    sb.settings++;
  endtask

  // Size register: mostly small planes, plus the ends and out-of-range codes
  function automatic bit [23:0] pick_size();
    bit [8:0] v;
    case ($urandom_range(0, 9))
      0: v = 9'd1;
      1: v = 9'd256;
      2: v = 9'd0;
      3: v = 9'($urandom_range(257, 511));
      4: v = 9'($urandom_range(17, 255));
      default: v = 9'($urandom_range(2, 16));
    endcase
    if ($urandom_range(0, 3) == 0) return {15'($urandom), v};
    return {15'd0, v};
  endfunction

  function automatic bit [23:0] pick_step();
    case ($urandom_range(0, 7))
      0: return 24'd0;
      1: return 24'hFFFFFF;
      2: return 24'd65536;
      3: return 24'($urandom);
      4: return 24'($urandom_range(1, 65535));
      default: return 24'($urandom_range(24'h2000, 24'h60000));
    endcase
  endfunction

  function automatic int unsigned pick_pct();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 5;
      2: return 30;
      default: return 12;
    endcase
  endfunction

  task automatic run_directed();
    // Exact hits and the far corner under the reset setting
    send_item(OP_STORE, 8'd0, 8'd0, 16'hFFFF);
    send_item(OP_STORE, 8'd1, 8'd0, 16'h0000);
    send_item(OP_STORE, 8'd0, 8'd1, 16'h0000);
    send_item(OP_STORE, 8'd1, 8'd1, 16'hFFFF);
    request_pixel(8'd0, 8'd0);
    send_item(OP_STORE, 8'd255, 8'd255, 16'hA5A5);
    request_pixel(8'd255, 8'd255);
    // 2x2 plane, half step, zero vertical step: clamps on both edges
    drain_requests();
    configure(24'd2, 24'd2, 24'h008000, 24'd0);
    request_pixel(8'd0, 8'd0);
    request_pixel(8'd3, 8'd0);
    request_pixel(8'd1, 8'd255);
    // Width register zero, height past the plane, widest step
    drain_requests();
    configure(24'd0, 24'd511, 24'hFFFFFF, 24'h020000);
    request_pixel(8'd255, 8'd0);
    request_pixel(8'd0, 8'd127);
    // Halfway between 0 and 1 rounds up
    drain_requests();
    configure(24'd256, 24'd1, 24'h020000, 24'd65536);
    send_item(OP_STORE, 8'd0, 8'd0, 16'd0);
    send_item(OP_STORE, 8'd1, 8'd0, 16'd1);
    request_pixel(8'd0, 8'd0);
  endtask

  task automatic run_random();
    int unsigned phase;
    int unsigned draw;
    phase = 0;
    while (sb.stores + sb.requests < TOTAL_ITEMS) begin
      drain_requests();
      configure(pick_size(), pick_size(), pick_step(), pick_step());
      gap_pct   = pick_pct();
      stall_pct = pick_pct();
      for (draw = 0; draw < PHASE_DRAWS && sb.stores + sb.requests < TOTAL_ITEMS; draw++) begin
        // no idling on either side over the last stretch
        if (sb.stores + sb.requests + CALM_ITEMS >= TOTAL_ITEMS) calm = 1'b1;
        // now and then the sender waits for every result mid-phase
        if (draw == PHASE_DRAWS / 2 && phase % 3 == 1) drain_requests();
        if ($urandom_range(0, 9) < 3)
          send_item(OP_STORE, 8'($urandom), 8'($urandom), 16'($urandom));
        else if ($urandom_range(0, 1) == 0)
          request_pixel(8'($urandom_range(0, 31)), 8'($urandom_range(0, 31)));
        else
          request_pixel(8'($urandom), 8'($urandom));
      end
      phase++;
    end
  endtask

  initial begin
    sb          = new();
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    op_i        = OP_STORE;
    column_i    = 8'd0;
    row_i       = 8'd0;
    pixel_in_i  = 16'd0;
    cfg_we_i    = 1'b0;
    cfg_index_i = CFG_WIDTH;
    cfg_data_i  = 24'd0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    run_directed();
    run_random();
    drain_requests();

    $display("%0d stores and %0d resize requests sent, %0d pixels checked",
             sb.stores, sb.requests, sb.results);
    $display("%0d register settings, %0d mismatches", sb.settings, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/bir_pkg.sv
rtl/bir_plane.sv
rtl/bir_coord.sv
rtl/bir_blend.sv
rtl/bilinear_image_resize.sv
tb/bilinear_image_resize_tb.sv
